### rtl/sphlm_pkg.sv
// Package: shared constants and types for the stereo peak-hold level meter.
`timescale 1ns / 1ps
`default_nettype none
package sphlm_pkg;

  localparam int LEVEL_FRAC_BITS = 16;
  localparam int HOLD_BITS_DEF   = 10;

  localparam int FACTOR_FRAC  = 16;
  localparam int SAMPLE_W     = 18;
  localparam int RELEASE_W    = 16;
  localparam int HOLD_TICKS_W = 10;
  localparam int THRESH_W     = 17;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [RELEASE_W-1:0]    LEVEL_RELEASE_RST  = 16'd58982;
  localparam logic [RELEASE_W-1:0]    PEAK_RELEASE_RST   = 16'd62259;
  localparam logic [HOLD_TICKS_W-1:0] HOLD_TICKS_RST     = 10'd30;
  localparam logic [THRESH_W-1:0]     IDLE_THRESHOLD_RST = 17'd66;

  typedef enum logic [1:0] {
    REG_LEVEL_RELEASE  = 2'd0,
    REG_PEAK_RELEASE   = 2'd1,
    REG_HOLD_TICKS     = 2'd2,
    REG_IDLE_THRESHOLD = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

### rtl/sphlm_in_if.sv
// Interface: input tick channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface sphlm_in_if;
  import sphlm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       have;
  logic signed [SAMPLE_W-1:0] sample_left;
  logic signed [SAMPLE_W-1:0] sample_right;

  modport source (output valid, have, sample_left, sample_right, input ready);
  modport sink   (input valid, have, sample_left, sample_right, output ready);
endinterface
`default_nettype wire

### rtl/sphlm_out_if.sv
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface sphlm_out_if #(
  parameter int VALUE_W = 17
);
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] level_left;
  logic [VALUE_W-1:0] peak_left;
  logic [VALUE_W-1:0] level_right;
  logic [VALUE_W-1:0] peak_right;
  logic               active;

  modport source (output valid, level_left, peak_left, level_right, peak_right, active,
                  input ready);
  modport sink   (input valid, level_left, peak_left, level_right, peak_right, active,
                  output ready);
endinterface
`default_nettype wire

### rtl/stereo_peak_hold_level_meter.sv
// Top level: stereo peak-hold level meter ballistics with APB configuration.
`timescale 1ns / 1ps
`default_nettype none
// Takes one tick transaction per clock unless a waiting result stalls, and returns
// one result transaction per tick via the input register, then the result register;
// the per-channel decay multiply, attack compare and threshold snap sit between them.
// Throughput is one tick per cycle while results are taken. While a result waits,
// one more tick is taken into the input register if it is empty. Levels and peaks
// are unsigned with LEVEL_FRAC_BITS fraction bits; full scale is 1 << LEVEL_FRAC_BITS.
// Registers are written over APB at byte addresses 0, 4, 8, 12 and read back there.
module stereo_peak_hold_level_meter #(
  parameter int HOLD_BITS = sphlm_pkg::HOLD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  sphlm_in_if.sink                               in_ch,
  sphlm_out_if.source                            out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [sphlm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [sphlm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [sphlm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                   cfg_pready
);
  import sphlm_pkg::*;

  localparam int VW = LEVEL_FRAC_BITS + 1;
  localparam int PW = VW + RELEASE_W;
  localparam logic [31:0] FULL_SCALE = 32'd1 << LEVEL_FRAC_BITS;

  // configuration registers
  logic [RELEASE_W-1:0]    level_release_r;
  logic [RELEASE_W-1:0]    peak_release_r;
  logic [HOLD_TICKS_W-1:0] hold_ticks_r;
  logic [THRESH_W-1:0]     idle_threshold_r;

  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_release_r  <= LEVEL_RELEASE_RST;
      peak_release_r   <= PEAK_RELEASE_RST;
      hold_ticks_r     <= HOLD_TICKS_RST;
      idle_threshold_r <= IDLE_THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LEVEL_RELEASE:  level_release_r  <= cfg_pwdata[RELEASE_W-1:0];
        REG_PEAK_RELEASE:   peak_release_r   <= cfg_pwdata[RELEASE_W-1:0];
        REG_HOLD_TICKS:     hold_ticks_r     <= cfg_pwdata[HOLD_TICKS_W-1:0];
        REG_IDLE_THRESHOLD: idle_threshold_r <= cfg_pwdata[THRESH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LEVEL_RELEASE:  cfg_prdata = CFG_DATA_W'(level_release_r);
      REG_PEAK_RELEASE:   cfg_prdata = CFG_DATA_W'(peak_release_r);
      REG_HOLD_TICKS:     cfg_prdata = CFG_DATA_W'(hold_ticks_r);
      REG_IDLE_THRESHOLD: cfg_prdata = CFG_DATA_W'(idle_threshold_r);
    endcase
  end

  // input register
  logic                       s1_valid_r;
  logic                       s1_have_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r [2];
  logic                       out_valid_r;
  logic                       advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_have_r      <= in_ch.have;
      s1_sample_r[0] <= in_ch.sample_left;
      s1_sample_r[1] <= in_ch.sample_right;
    end
  end

  // channel state, index 0 is left, 1 is right
  logic [VW-1:0]        level_r [2];
  logic [VW-1:0]        peak_r  [2];
  logic [HOLD_BITS-1:0] hold_r  [2];
  logic [VW-1:0]        level_nxt [2];
  logic [VW-1:0]        peak_nxt  [2];
  logic [HOLD_BITS-1:0] hold_nxt  [2];

  logic [HOLD_BITS+HOLD_TICKS_W-1:0] reload_ext;
  logic [HOLD_BITS-1:0]              hold_reload;
  logic [PW-1:0]                     lvl_prod [2];
  logic [PW-1:0]                     pk_prod  [2];
  logic [31:0]                       smp_mag  [2];
  logic [VW-1:0]                     smp_clip [2];
  logic                              active_nxt;

  assign reload_ext  = {{HOLD_BITS{1'b0}}, hold_ticks_r};
  assign hold_reload = reload_ext[HOLD_BITS-1:0];

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      lvl_prod[ch] = PW'(level_r[ch]) * PW'(level_release_r);
      pk_prod[ch]  = PW'(peak_r[ch]) * PW'(peak_release_r);
      level_nxt[ch] = lvl_prod[ch][PW-1:FACTOR_FRAC];
      if (hold_r[ch] != '0) begin
        hold_nxt[ch] = hold_r[ch] - HOLD_BITS'(1);
        peak_nxt[ch] = peak_r[ch];
      end else begin
        hold_nxt[ch] = hold_r[ch];
        peak_nxt[ch] = pk_prod[ch][PW-1:FACTOR_FRAC];
      end

      smp_mag[ch] = 32'(s1_sample_r[ch][SAMPLE_W-2:0]);
      if (s1_sample_r[ch][SAMPLE_W-1]) begin
        smp_clip[ch] = '0;
      end else if (smp_mag[ch] > FULL_SCALE) begin
        smp_clip[ch] = FULL_SCALE[VW-1:0];
      end else begin
        smp_clip[ch] = smp_mag[ch][VW-1:0];
      end
      if (s1_have_r && (smp_clip[ch] > level_nxt[ch])) begin
        level_nxt[ch] = smp_clip[ch];
      end

      if (level_nxt[ch] > peak_nxt[ch]) begin
        peak_nxt[ch] = level_nxt[ch];
        hold_nxt[ch] = hold_reload;
      end

      if (32'(level_nxt[ch]) < 32'(idle_threshold_r)) level_nxt[ch] = '0;
      if (32'(peak_nxt[ch]) < 32'(idle_threshold_r))  peak_nxt[ch]  = '0;
    end
    active_nxt = (level_nxt[0] != '0) || (peak_nxt[0] != '0) ||
                 (level_nxt[1] != '0) || (peak_nxt[1] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < 2; ch++) begin
        level_r[ch] <= '0;
        peak_r[ch]  <= '0;
        hold_r[ch]  <= '0;
      end
    end else if (advance) begin
      for (int ch = 0; ch < 2; ch++) begin
        level_r[ch] <= level_nxt[ch];
        peak_r[ch]  <= peak_nxt[ch];
        hold_r[ch]  <= hold_nxt[ch];
      end
    end
  end

  // result register
  logic out_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_active_r <= active_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.level_left  = level_r[0];
  assign out_ch.peak_left   = peak_r[0];
  assign out_ch.level_right = level_r[1];
  assign out_ch.peak_right  = peak_r[1];
  assign out_ch.active      = out_active_r;

  // checks
  a_level_under_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r[0] <= peak_r[0]) && (level_r[1] <= peak_r[1]))
    else $error("level above held peak");

  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(peak_r[0]) <= FULL_SCALE) && (32'(peak_r[1]) <= FULL_SCALE))
    else $error("peak above full scale");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("pending tick dropped");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(level_r[0]) && $stable(peak_r[1]) && $stable(hold_r[0])))
    else $error("channel state changed without a tick");

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for stereo_peak_hold_level_meter: directed table plus random ticks, self-checked.
`timescale 1ns / 1ps
module tb;
  import sphlm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_LIMIT    = 200;
  localparam int RANDOM_PER_SET = 90;
  localparam int NUM_SETS       = 6;
  localparam int QUIET_SET      = 5;
  localparam int NUM_DIRECTED   = 20;
  localparam logic [16:0] FULL_SCALE = 17'd65536;

  typedef struct packed {
    logic [16:0] level_left;
    logic [16:0] peak_left;
    logic [16:0] level_right;
    logic [16:0] peak_right;
    logic        active;
  } meter_out_t;

  typedef struct packed {
    logic [16:0]             level;
    logic [16:0]             peak;
    logic [HOLD_TICKS_W-1:0] hold;
  } chan_t;

  typedef struct packed {
    logic                have;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                typed;
    meter_out_t          want;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] level_rel;
    logic [CFG_DATA_W-1:0] peak_rel;
    logic [CFG_DATA_W-1:0] hold;
    logic [CFG_DATA_W-1:0] floor;
  } cfg_set_t;

  typedef struct {
    bit         typed;
    meter_out_t want;
  } tick_note_t;

  localparam meter_out_t NO_WANT = '0;

  // typed rows: reset state, full-scale attack, clamp from above full scale
  localparam dir_row_t DIR_ROWS [NUM_DIRECTED] = '{
    '{1'b0, 18'h00000, 18'h00000, 1'b1, '{17'd0, 17'd0, 17'd0, 17'd0, 1'b0}},
    '{1'b1, 18'h10000, 18'h20000, 1'b1, '{17'd65536, 17'd65536, 17'd0, 17'd0, 1'b1}},
    '{1'b1, 18'h1FFFF, 18'h3FFFF, 1'b1, '{17'd65536, 17'd65536, 17'd0, 17'd0, 1'b1}},
    '{1'b1, 18'h1FFFF, 18'h10000, 1'b0, NO_WANT},
    '{1'b1, 18'h10001, 18'h3FFFF, 1'b0, NO_WANT},
    '{1'b0, 18'h10000, 18'h10000, 1'b0, NO_WANT},
    '{1'b0, 18'h00000, 18'h00000, 1'b0, NO_WANT},
    '{1'b1, 18'h00041, 18'h00042, 1'b0, NO_WANT},
    '{1'b1, 18'h20000, 18'h1FFFF, 1'b0, NO_WANT},
    '{1'b1, 18'h08000, 18'h00001, 1'b0, NO_WANT},
    '{1'b1, 18'h0FFFF, 18'h2AAAA, 1'b0, NO_WANT},
    '{1'b1, 18'h15555, 18'h0AAAA, 1'b0, NO_WANT},
    '{1'b0, 18'h3FFFF, 18'h3FFFF, 1'b0, NO_WANT},
    '{1'b0, 18'h00000, 18'h00000, 1'b0, NO_WANT},
    '{1'b0, 18'h15555, 18'h2AAAA, 1'b0, NO_WANT},
    '{1'b0, 18'h00000, 18'h00000, 1'b0, NO_WANT},
    '{1'b0, 18'h00000, 18'h00000, 1'b0, NO_WANT},
    '{1'b0, 18'h00000, 18'h00000, 1'b0, NO_WANT},
    '{1'b1, 18'h00000, 18'h00000, 1'b0, NO_WANT},
    '{1'b1, 18'h3FFFF, 18'h00043, 1'b0, NO_WANT}
  };

  // set 0 is the reset state; upper bits beyond each register's width are set on purpose
  localparam cfg_set_t CFG_SETS [NUM_SETS] = '{
    '{32'd58982, 32'd62259, 32'd30, 32'd66},
    '{32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_03FF, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
    '{32'hABCD_8000, 32'h1234_C000, 32'h0000_0403, 32'hFFFF_FFFF},
    '{32'd60000, 32'd50000, 32'd5, 32'd200},
    '{32'd58982, 32'd62259, 32'd30, 32'd66}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sphlm_in_if               in_if ();
  sphlm_out_if #(.VALUE_W(17)) out_if ();

  stereo_peak_hold_level_meter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state and register mirror
  chan_t meter_left  = '0;
  chan_t meter_right = '0;
  logic [RELEASE_W-1:0]    rel_level   = LEVEL_RELEASE_RST;
  logic [RELEASE_W-1:0]    rel_peak    = PEAK_RELEASE_RST;
  logic [HOLD_TICKS_W-1:0] hold_reload = HOLD_TICKS_RST;
  logic [THRESH_W-1:0]     idle_floor  = IDLE_THRESHOLD_RST;

  meter_out_t meter_expect [$];
  tick_note_t tick_notes [$];

  int fail_count   = 0;
  int results_seen = 0;
  int ticks_sent   = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;
  bit gaps_off     = 1'b0;

  function automatic chan_t ballistics_tick(chan_t c, logic have, logic [SAMPLE_W-1:0] raw);
    logic [32:0] prod;
    logic [16:0] clamped;
    prod = c.level * rel_level;
    c.level = prod[32:16];
    if (c.hold != '0) begin
      c.hold = c.hold - 1'b1;
    end else begin
      prod = c.peak * rel_peak;
      c.peak = prod[32:16];
    end
    if (raw[SAMPLE_W-1]) begin
      clamped = '0;
    end else if (raw > {1'b0, FULL_SCALE}) begin
      clamped = FULL_SCALE;
    end else begin
      clamped = raw[16:0];
    end
    if (have && clamped > c.level) begin
      c.level = clamped;
    end
    if (c.level > c.peak) begin
      c.peak = c.level;
      c.hold = hold_reload;
    end
    if (c.level < idle_floor) begin
      c.level = '0;
    end
    if (c.peak < idle_floor) begin
      c.peak = '0;
    end
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(bit near_floor);
    int near;
    near = int'(idle_floor) + int'($urandom_range(6)) - 3;
    if (near < 0) begin
      near = 0;
    end
    if (near_floor) begin
      return SAMPLE_W'(near);
    end
    case ($urandom_range(9))
      0: return {1'b1, 17'($urandom())};
      1: return {1'b0, FULL_SCALE};
      2: return SAMPLE_W'($urandom_range(131071, 65537));
      3: return '0;
      4: return SAMPLE_W'(near);
      default: return SAMPLE_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(meter_out_t got, meter_out_t want);
    if (got.level_left !== want.level_left)
      report_mismatch("level_left", got.level_left, want.level_left);
    if (got.peak_left !== want.peak_left)
      report_mismatch("peak_left", got.peak_left, want.peak_left);
    if (got.level_right !== want.level_right)
      report_mismatch("level_right", got.level_right, want.level_right);
    if (got.peak_right !== want.peak_right)
      report_mismatch("peak_right", got.peak_right, want.peak_right);
    if (got.active !== want.active)
      report_mismatch("active", got.active, want.active);
  endtask

  // result check first, then prediction for the tick accepted at this edge
  always @(posedge clk) begin
    meter_out_t got;
    meter_out_t want;
    tick_note_t note;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.level_left, out_if.peak_left, out_if.level_right,
                out_if.peak_right, out_if.active};
        results_seen++;
        if (meter_expect.size() == 0) begin
          report_mismatch("unexpected transaction, level_left", got.level_left, 0);
        end else begin
          want = meter_expect.pop_front();
          check_result(got, want);
        end
      end
      if (in_if.valid && in_if.ready) begin
        meter_left  = ballistics_tick(meter_left, in_if.have, in_if.sample_left);
        meter_right = ballistics_tick(meter_right, in_if.have, in_if.sample_right);
        want = '{meter_left.level, meter_left.peak, meter_right.level, meter_right.peak,
                 |{meter_left.level, meter_left.peak, meter_right.level, meter_right.peak}};
        if (tick_notes.size() == 0) begin
          report_mismatch("tick accepted with none driven", 0, 0);
        end else begin
          note = tick_notes.pop_front();
          if (note.typed) begin
            want = note.want;
          end
        end
        meter_expect.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= gaps_off || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_tick(logic have, logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                           bit typed, meter_out_t want);
    tick_notes.push_back('{typed, want});
    while (!gaps_off && $urandom_range(99) < 34) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.have         <= have;
    in_if.sample_left  <= left;
    in_if.sample_right <= right;
    ticks_sent++;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // leaves psel high; the caller closes the burst of writes
  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_LEVEL_RELEASE:  rel_level   = value[RELEASE_W-1:0];
      REG_PEAK_RELEASE:   rel_peak    = value[RELEASE_W-1:0];
      REG_HOLD_TICKS:     hold_reload = value[HOLD_TICKS_W-1:0];
      REG_IDLE_THRESHOLD: idle_floor  = value[THRESH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && (meter_expect.size() != 0 || tick_notes.size() != 0);
         w++) begin
      @(posedge clk);
    end
    if (meter_expect.size() != 0) begin
      report_mismatch("results never returned", meter_expect.size(), 0);
      meter_expect.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int seg_left;
    int seg_mode;
    logic have;
    rst_n              <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    in_if.valid        <= 1'b0;
    in_if.have         <= 1'b0;
    in_if.sample_left  <= '0;
    in_if.sample_right <= '0;
    seg_left = 0;
    seg_mode = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      send_tick(DIR_ROWS[i].have, DIR_ROWS[i].left, DIR_ROWS[i].right,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int s = 0; s < NUM_SETS; s++) begin
      if (s > 0) begin
        drain_results();
        cfg_write(REG_LEVEL_RELEASE, CFG_SETS[s].level_rel);
        cfg_write(REG_PEAK_RELEASE, CFG_SETS[s].peak_rel);
        cfg_write(REG_HOLD_TICKS, CFG_SETS[s].hold);
        cfg_write(REG_IDLE_THRESHOLD, CFG_SETS[s].floor);
        cfg_psel    <= 1'b0;
        cfg_penable <= 1'b0;
        cfg_pwrite  <= 1'b0;
      end
      gaps_off = (s == QUIET_SET);
      for (int i = 0; i < RANDOM_PER_SET; i++) begin
        // segments: decay only, near threshold, or loud program material
        if (seg_left == 0) begin
          seg_left = $urandom_range(24, 1);
          seg_mode = $urandom_range(3);
        end
        seg_left--;
        case (seg_mode)
          0: send_tick(1'b0, random_sample(1'b0), random_sample(1'b0), 1'b0, NO_WANT);
          1: send_tick(1'b1, random_sample(1'b1), random_sample(1'b1), 1'b0, NO_WANT);
          default: begin
            have = ($urandom_range(99) < 85);
            send_tick(have, random_sample(1'b0), random_sample(1'b0), 1'b0, NO_WANT);
          end
        endcase
      end
    end
    drain_results();
    gaps_off = 1'b0;

    $display("Sent %0d ticks (%0d directed) under %0d register settings, %0d writes.",
             ticks_sent, NUM_DIRECTED, NUM_SETS, reg_writes);
    $display("Checked %0d results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
